FILE: src/dbm_pkg.sv
// Shared types, constants and the quarter-wave sine table for the DFT bin engine.
// No dependencies; imported by every module of the block.
package dbm_pkg;

    localparam int PTS    = 256;
    localparam int AW     = $clog2(PTS);
    localparam int ACC_W  = 25;
    localparam int RAD_W  = 48;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [14:0] Q15_ONE = 15'd32767;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BIN  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        sample_index;
        logic signed [15:0] sample_value;
        logic [7:0]        bin_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         bin_number;
        logic signed [31:0] real_part;
        logic signed [31:0] imag_part;
        logic [31:0]        magnitude;
    } t_out_item;

    // Finished sums handed from the MAC engine to the root unit
    typedef struct packed {
        logic [7:0]              bin_number;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_sums;

    typedef enum logic [1:0] {
        E_IDLE,
        E_RUN,
        E_DRAIN,
        E_HAND
    } t_eng_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ITER,
        S_DONE
    } t_root_state;

    typedef logic [14:0] t_tab [PTS];

    // Taylor series of sin through x^13, Q30, each term truncated
    function automatic logic [14:0] quarter_sin(input logic [63:0] r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        x    = (HALF_PI_Q30 * r + 64'(PTS / 2)) >> AW;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        rnd = (64'(sum) + 64'd16384) >> 15;
        if (rnd > 64'(Q15_ONE)) begin
            rnd = 64'(Q15_ONE);
        end
        return rnd[14:0];
    endfunction

    function automatic t_tab build_tab();
        t_tab tab;
        for (int i = 0; i < PTS; i++) begin
            tab[i] = (i == 0) ? 15'd0 : quarter_sin(64'(i));
        end
        return tab;
    endfunction

    localparam t_tab SIN_TAB = build_tab();

endpackage

FILE: src/dbm_front.sv
// Front end: takes input transactions into a two-entry queue for the engine.
// Depends on dbm_pkg.
module dbm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  dbm_pkg::t_in_item i_in,
    output logic             o_q_valid,
    output dbm_pkg::t_in_item o_q_item,
    input  logic             i_q_pop
);
    import dbm_pkg::*;

    t_in_item   r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_buf[r_rp];

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_in;
        end
    end

    // Advance the pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: src/dbm_engine.sv
// Back end: sample store, twiddle lookup and the two multiply-accumulate lanes.
// Depends on dbm_pkg; fed by dbm_front, feeds dbm_root.
module dbm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  dbm_pkg::t_in_item i_q_item,
    output logic              o_q_pop,
    output logic              o_sums_valid,
    output dbm_pkg::t_sums    o_sums,
    input  logic              i_sums_ready
);
    import dbm_pkg::*;

    logic signed [15:0] r_store [PTS];

    t_eng_state r_state;
    t_eng_state n_state;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] r_phase;
    logic [AW-1:0] r_k;
    logic [7:0]    r_bin;

    logic               issue;
    logic               start;
    logic               wr_en;
    logic signed [15:0] r_x1;
    logic [AW-1:0]      r_ph1;
    logic               r_v1;
    logic signed [15:0] r_x2;
    logic signed [15:0] r_c;
    logic signed [15:0] r_s;
    logic               r_v2;
    logic signed [16:0] r_pc;
    logic signed [16:0] r_ps;
    logic               r_v3;
    logic signed [ACC_W-1:0] r_re;
    logic signed [ACC_W-1:0] r_im;

    logic [1:0]         quad;
    logic [AW-1:0]      rem;
    logic signed [15:0] sq;
    logic signed [15:0] cq;
    logic signed [15:0] c_tw;
    logic signed [15:0] s_tw;
    logic signed [31:0] prod_c;
    logic signed [31:0] prod_s;

    // Sequence the pop, the sample walk and the hand-off
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        start   = 1'b0;
        wr_en   = 1'b0;
        issue   = 1'b0;
        o_sums_valid = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.req_type == REQ_LOAD) begin
                        wr_en = 1'b1;
                    end else begin
                        start   = 1'b1;
                        n_state = E_RUN;
                    end
                end
            end
            E_RUN: begin
                issue = 1'b1;
                if (r_cnt == (AW+1)'(PTS - 1)) begin
                    n_state = E_DRAIN;
                end
            end
            E_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = E_HAND;
                end
            end
            E_HAND: begin
                o_sums_valid = 1'b1;
                if (i_sums_ready) begin
                    n_state = E_IDLE;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
        end
    end

    // Sample store: write on load, registered read during the walk
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[i_q_item.sample_index[AW-1:0]] <= i_q_item.sample_value;
        end
        r_x1 <= r_store[r_cnt[AW-1:0]];
    end

    // Walk counter and phase k*n mod PTS kept as a running sum
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cnt   <= '0;
            r_phase <= '0;
            r_k     <= i_q_item.bin_index[AW-1:0];
            r_bin   <= i_q_item.bin_index;
        end else if (issue) begin
            r_cnt   <= r_cnt + 1'b1;
            r_phase <= r_phase + r_k;
        end
        r_ph1 <= r_phase;
    end

    // Twiddle from quadrant and quarter-wave table
    always_comb begin
        quad = r_ph1[AW-1:AW-2];
        rem  = {r_ph1[AW-3:0], 2'b00};
        if (rem == '0) begin
            sq = 16'sd0;
            cq = $signed({1'b0, Q15_ONE});
        end else begin
            sq = $signed({1'b0, SIN_TAB[rem]});
            cq = $signed({1'b0, SIN_TAB[AW'(PTS) - rem]});
        end
        case (quad)
            2'd0:    begin c_tw = cq;  s_tw = sq;  end
            2'd1:    begin c_tw = -sq; s_tw = cq;  end
            2'd2:    begin c_tw = -cq; s_tw = -sq; end
            default: begin c_tw = sq;  s_tw = -cq; end
        endcase
    end

    assign prod_c = r_x2 * r_c;
    assign prod_s = r_x2 * r_s;

    // Twiddle, multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        r_x2 <= r_x1;
        r_c  <= c_tw;
        r_s  <= s_tw;
        r_pc <= prod_c[31:15];
        r_ps <= prod_s[31:15];
        if (start) begin
            r_re <= '0;
            r_im <= '0;
        end else if (r_v3) begin
            r_re <= r_re + ACC_W'(r_pc);
            r_im <= r_im + ACC_W'(r_ps);
        end
    end

    assign o_sums.bin_number = r_bin;
    assign o_sums.re         = r_re;
    assign o_sums.im         = r_im;

endmodule

FILE: src/dbm_root.sv
// Magnitude unit: squares the sums, takes the integer root a bit per cycle,
// and holds the result transaction. Depends on dbm_pkg.
module dbm_root (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sums_valid,
    input  dbm_pkg::t_sums    i_sums,
    output logic              o_sums_ready,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dbm_pkg::t_out_item o_out
);
    import dbm_pkg::*;

    t_root_state r_state;
    t_root_state n_state;
    t_sums       r_sums;
    logic [RAD_W-1:0] r_sq_re;
    logic [RAD_W-1:0] r_sq_im;
    logic [RAD_W-1:0] r_rem;
    logic [RAD_W-1:0] r_res;
    logic [RAD_W-1:0] r_bit;
    logic [$clog2(ROOT_STEPS)-1:0] r_step;
    logic             r_out_valid;
    t_out_item        r_out;
    logic             load_out;
    logic [RAD_W-1:0] trial;
    logic signed [2*ACC_W-1:0] sq_re;
    logic signed [2*ACC_W-1:0] sq_im;

    assign trial = r_res + r_bit;
    assign sq_re = r_sums.re * r_sums.re;
    assign sq_im = r_sums.im * r_sums.im;

    // Next state and hand-off to the output register
    always_comb begin
        n_state      = r_state;
        o_sums_ready = 1'b0;
        load_out     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_sums_ready = 1'b1;
                if (i_sums_valid) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_ITER;
            S_ITER: begin
                if (r_step == $bits(r_step)'(ROOT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Squares, radicand and the restoring root iterations
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_sums_valid) begin
            r_sums <= i_sums;
        end
        r_sq_re <= sq_re[RAD_W-1:0];
        r_sq_im <= sq_im[RAD_W-1:0];
        if (r_state == S_SUM) begin
            r_rem  <= r_sq_re + r_sq_im;
            r_res  <= '0;
            r_bit  <= RAD_W'(1) << (RAD_W - 2);
            r_step <= '0;
        end else if (r_state == S_ITER) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step + 1'b1;
        end
        if (load_out) begin
            r_out.bin_number <= r_sums.bin_number;
            r_out.real_part  <= 32'(r_sums.re);
            r_out.imag_part  <= 32'(r_sums.im);
            r_out.magnitude  <= r_res[31:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: src/dft_bin_with_magnitude.sv
// Top level of the 256-point direct DFT bin server.
// Depends on dbm_pkg, dbm_front, dbm_engine and dbm_root.
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_in  (t_in_item)
//  output    out        o_out_valid / i_out_stall    o_out (t_out_item)
//
// A load transaction writes the sample store and gives no result.
// A bin transaction goes from acceptance to a valid result in these steps: the pop,
// 256 store reads, one per cycle through the single read port, the drain of the MAC
// pipeline, the hand-off, then the squaring, sum and root iterations in the root unit.
// The two-entry input queue accepts transactions while the engine is busy.
// Reset is synchronous and active low; the sample store is not cleared.
// A stalled result is held in the output register while the next bin runs.
module dft_bin_with_magnitude (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dbm_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dbm_pkg::t_out_item o_out
);
    import dbm_pkg::*;

    logic     q_valid;
    t_in_item q_item;
    logic     q_pop;
    logic     sums_valid;
    t_sums    sums;
    logic     sums_ready;

    dbm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    dbm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_sums_valid (sums_valid),
        .o_sums       (sums),
        .i_sums_ready (sums_ready)
    );

    dbm_root u_root (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sums_valid (sums_valid),
        .i_sums       (sums),
        .o_sums_ready (sums_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

FILE: src/dbm_checker.sv
// Port-level checks for the DFT bin server, bound to the top level.
// Depends on dbm_pkg.
module dbm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input dbm_pkg::t_out_item o_out
);
    import dbm_pkg::*;

    logic [63:0] mag2;
    logic [63:0] root_sq;
    logic [63:0] next_sq;

    assign mag2 = 64'(64'($signed(o_out.real_part)) * 64'($signed(o_out.real_part)))
                + 64'(64'($signed(o_out.imag_part)) * 64'($signed(o_out.imag_part)));
    assign root_sq = 64'(o_out.magnitude) * 64'(o_out.magnitude);
    assign next_sq = (64'(o_out.magnitude) + 64'd1) * (64'(o_out.magnitude) + 64'd1);

    // No result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Magnitude is the floor root of the power
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (root_sq <= mag2) && (next_sq > mag2))
        else $error("magnitude not floor root");

    // Sums of 256 scaled products stay within plus or minus 2^23
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_out.real_part) <= 32'sd8388608)
            && ($signed(o_out.real_part) >= -32'sd8388608)
            && ($signed(o_out.imag_part) <= 32'sd8388608)
            && ($signed(o_out.imag_part) >= -32'sd8388608))
        else $error("sum out of range");

endmodule

bind dft_bin_with_magnitude dbm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

FILE: bench/dbm_checker.sv
// Scoreboard for the DFT bin server: watches both channels, predicts each bin
// result from a private copy of the sample store and compares it field by field.
// Depends on dbm_pkg for the transaction types.
`timescale 1ns / 100ps

module dbm_scoreboard (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  dbm_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  dbm_pkg::t_out_item i_out,
    output int                 o_errors,
    output int                 o_pending
);
    import dbm_pkg::*;

    localparam int NPTS = 256;
    localparam longint unsigned HALF_PI = 64'd1686629713;

    logic signed [15:0] samples [NPTS];
    int                 cos_tab [NPTS];
    int                 sin_tab [NPTS];
    t_out_item          bins_due [$];

    // Truncated Taylor sine of the quarter angle, rounded to Q15
    function automatic int q15_sine(input int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        longint unsigned rounded;
        x = (HALF_PI * r + 64'd128) / 64'd256;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int i = 1; i <= 6; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (longint'(acc) + 64'd16384) >> 15;
        if (rounded > 64'd32767) begin
            rounded = 64'd32767;
        end
        return int'(rounded);
    endfunction

    // Floor square root, one result bit per pass
    function automatic logic [31:0] floor_root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) begin
            bitv = bitv >> 2;
        end
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Sum the stored samples against the twiddles of bin k
    function automatic t_out_item bin_sums(input logic [7:0] k);
        t_out_item          res;
        longint             re;
        longint             im;
        int                 m;
        longint signed      x;
        logic signed [31:0] r32;
        logic signed [31:0] i32;
        re = 0;
        im = 0;
        for (int n = 0; n < NPTS; n++) begin
            m = (int'(k) * n) % NPTS;
            x = samples[n];
            re = re + ((x * cos_tab[m]) >>> 15);
            im = im + ((x * sin_tab[m]) >>> 15);
        end
        r32 = clamp32(re);
        i32 = clamp32(im);
        res.bin_number = k;
        res.real_part = r32;
        res.imag_part = i32;
        res.magnitude = floor_root(longint'(unsigned'(longint'(r32) * r32))
                                   + longint'(unsigned'(longint'(i32) * i32)));
        return res;
    endfunction

    // Build the twiddle tables from the quadrant mapping
    initial begin
        int q;
        int r;
        int sq;
        int cq;
        for (int m = 0; m < NPTS; m++) begin
            q = (4 * m) / NPTS;
            r = (4 * m) % NPTS;
            if (r == 0) begin
                sq = 0;
                cq = 32767;
            end else begin
                sq = q15_sine(r);
                cq = q15_sine(NPTS - r);
            end
            case (q % 4)
                0: begin cos_tab[m] = cq;  sin_tab[m] = sq;  end
                1: begin cos_tab[m] = -sq; sin_tab[m] = cq;  end
                2: begin cos_tab[m] = -cq; sin_tab[m] = -sq; end
                default: begin cos_tab[m] = sq; sin_tab[m] = -cq; end
            endcase
        end
        for (int n = 0; n < NPTS; n++) begin
            samples[n] = '0;
        end
        o_errors = 0;
    end

    assign o_pending = bins_due.size();

    // Predict on accepted input, compare on accepted output
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            if (i_in.req_type == REQ_LOAD) begin
                samples[i_in.sample_index] = i_in.sample_value;
            end else begin
                bins_due.push_back(bin_sums(i_in.bin_index));
            end
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (bins_due.size() == 0) begin
                $display("%0t: unexpected result transaction %h", $time, i_out);
                o_errors = o_errors + 1;
            end else begin
                due = bins_due.pop_front();
                if (due.bin_number !== i_out.bin_number) begin
                    $display("%0t: bin_number expected %0d actual %0d", $time,
                             due.bin_number, i_out.bin_number);
                    o_errors = o_errors + 1;
                end
                if (due.real_part !== i_out.real_part) begin
                    $display("%0t: real_part expected %0d actual %0d", $time,
                             due.real_part, i_out.real_part);
                    o_errors = o_errors + 1;
                end
                if (due.imag_part !== i_out.imag_part) begin
                    $display("%0t: imag_part expected %0d actual %0d", $time,
                             due.imag_part, i_out.imag_part);
                    o_errors = o_errors + 1;
                end
                if (due.magnitude !== i_out.magnitude) begin
                    $display("%0t: magnitude expected %0d actual %0d", $time,
                             due.magnitude, i_out.magnitude);
                    o_errors = o_errors + 1;
                end
            end
        end
    end

endmodule

FILE: bench/dft_bin_with_magnitude_tb.sv
// Top of the DFT bin server bench: clock, reset, stimulus and verdict.
// Depends on dbm_pkg, the block and dbm_scoreboard.
`timescale 1ns / 100ps

module dft_bin_with_magnitude_tb;
    import dbm_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        errors;
    int        pending;
    int        tx_idle;
    int        rx_idle;
    logic      hold_req;

    dft_bin_with_magnitude dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    dbm_scoreboard u_scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out       (out_item),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result channel at random; hold it off for a long stretch on request
    initial begin
        int held;
        out_stall = 1'b1;
        held = 0;
        forever begin
            @(negedge clk);
            if (hold_req && held < 2000) begin
                held = held + 1;
                out_stall <= 1'b1;
            end else begin
                if (!hold_req) begin
                    held = 0;
                end
                out_stall <= ($urandom_range(99) < rx_idle);
            end
        end
    end

    // Offer one transaction, with a random gap first, and hold it until taken
    task automatic offer(input t_in_item item);
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        do begin
            @(posedge clk);
        end while (in_stall);
        @(negedge clk);
    endtask

    task automatic load(input logic [7:0] idx, input logic signed [15:0] val);
        t_in_item item;
        item = '0;
        item.req_type = REQ_LOAD;
        item.sample_index = idx;
        item.sample_value = val;
        item.bin_index = 8'($urandom);
        offer(item);
    endtask

    task automatic ask_bin(input logic [7:0] k);
        t_in_item item;
        item = '0;
        item.req_type = REQ_BIN;
        item.bin_index = k;
        item.sample_index = 8'($urandom);
        item.sample_value = 16'($urandom);
        offer(item);
    endtask

    // Drop the offer and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Mostly random samples, sometimes an extreme
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        in_valid = 1'b0;
        in_item = '0;
        hold_req = 1'b0;
        tx_idle = 31;
        rx_idle = 83;
        rst_n = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole store at full scale before any bin is asked for
        for (int n = 0; n < 256; n++) begin
            load(8'(n), 16'sh7fff);
        end
        ask_bin(8'd0);
        ask_bin(8'd1);
        ask_bin(8'd64);
        ask_bin(8'd128);
        ask_bin(8'd255);
        drain();
        // Negative full scale over part of the store, then a few bins
        for (int n = 0; n < 256; n += 17) begin
            load(8'(n), 16'sh8000);
        end
        load(8'd255, 16'sh8000);
        ask_bin(8'd0);
        ask_bin(8'd127);
        ask_bin(8'd200);

        // Random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            tx_idle = (phase == 0) ? 31 : (phase == 1) ? 83 : 0;
            rx_idle = (phase == 0) ? 83 : (phase == 1) ? 31 : 0;
            for (int i = 0; i < 72; i++) begin
                if ($urandom_range(99) < 60) begin
                    load(8'($urandom), pick_sample());
                end else begin
                    ask_bin(8'($urandom));
                end
            end
        end

        // Hold the result channel off while bins keep coming, so the input backs up
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) begin
            ask_bin(8'($urandom));
        end
        hold_req = 1'b0;

        drain();
        repeat (400) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("dft_bin_with_magnitude_tb: PASS");
        end else begin
            $display("dft_bin_with_magnitude_tb: FAIL");
        end
        $finish;
    end

    // End the run if it hangs
    initial begin
        #15000000;
        $display("dft_bin_with_magnitude_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/dbm_pkg.sv
src/dbm_front.sv
src/dbm_engine.sv
src/dbm_root.sv
src/dft_bin_with_magnitude.sv
src/dbm_checker.sv
bench/dbm_checker.sv
bench/dft_bin_with_magnitude_tb.sv
